@@ rtl/ray_box_slab_intersect_top_macros.svh @@
// Assertion macros for the ray box slab intersect block
`ifndef RAY_BOX_SLAB_INTERSECT_TOP_MACROS_SVH
`define RAY_BOX_SLAB_INTERSECT_TOP_MACROS_SVH

// Check a plain property on the rising clock, off while in reset
`define RBS_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check an implication on the rising clock, off while in reset
`define RBS_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ rtl/rbs_pkg.sv @@
`default_nettype none
package rbs_pkg;

    localparam int DATA_W                = 32;
    localparam int DIR_W                 = 18;
    localparam int QUO_W                 = 32;
    localparam int FRACTION_BITS_DEFAULT = 16;
    localparam int CFG_IDX_W             = 4;
    localparam int NUM_AXES              = 3;

    // Divider: one input stage, one stage per quotient bit, one saturate stage
    localparam int DIV_LAT  = QUO_W + 2;
    // Front stage, divider, two back stages
    localparam int PIPE_LAT = DIV_LAT + 3;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BOX_MIN_X = 4'd0,
        REG_BOX_MIN_Y = 4'd1,
        REG_BOX_MIN_Z = 4'd2,
        REG_BOX_MAX_X = 4'd3,
        REG_BOX_MAX_Y = 4'd4,
        REG_BOX_MAX_Z = 4'd5,
        REG_RANGE_MIN = 4'd6,
        REG_RANGE_MAX = 4'd7
    } cfg_reg_t;

    localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;

    // Per-transaction sideband that rides beside the dividers
    typedef struct packed {
        logic                miss;
        logic [NUM_AXES-1:0] zero;
    } side_t;

endpackage
`default_nettype wire

@@ rtl/ray_box_slab_intersect_top.sv @@
// Channel   | Handshake          | Payload
// ----------+--------------------+-------------------------------------------
// input     | start, busy        | ray_org_x/y/z, direction_x/y/z
// config    | cfg_we             | cfg_index, cfg_data
// result    | done               | entry_distance, exit_distance, hit
//
// One transaction enters per cycle; busy stays low.
// Each result passes the front stage, the restoring dividers with their
// 32 stages of one quotient bit each, and the back stages.
// Reset clears the valid bits and loads the register defaults.
// The result side cannot stall, so the pipeline never holds.
`default_nettype none
module ray_box_slab_intersect_top #(
    parameter int FRACTION_BITS = rbs_pkg::FRACTION_BITS_DEFAULT
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 start,
    output logic                                      busy,
    input  wire logic signed [rbs_pkg::DATA_W-1:0]    ray_org_x,
    input  wire logic signed [rbs_pkg::DATA_W-1:0]    ray_org_y,
    input  wire logic signed [rbs_pkg::DATA_W-1:0]    ray_org_z,
    input  wire logic signed [rbs_pkg::DIR_W-1:0]     direction_x,
    input  wire logic signed [rbs_pkg::DIR_W-1:0]     direction_y,
    input  wire logic signed [rbs_pkg::DIR_W-1:0]     direction_z,
    input  wire logic                                 cfg_we,
    input  wire logic [rbs_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [rbs_pkg::DATA_W-1:0]           cfg_data,
    output logic                                      done,
    output logic signed [rbs_pkg::DATA_W-1:0]         entry_distance,
    output logic signed [rbs_pkg::DATA_W-1:0]         exit_distance,
    output logic                                      hit
);
    import rbs_pkg::*;

    localparam int NW = DATA_W + 1 + FRACTION_BITS;

    logic signed [DATA_W-1:0] box_min_reg [NUM_AXES];
    logic signed [DATA_W-1:0] box_max_reg [NUM_AXES];
    logic signed [DATA_W-1:0] range_min_reg, range_max_reg;

    logic signed [DATA_W-1:0] org [NUM_AXES];
    logic signed [DIR_W-1:0]  dir [NUM_AXES];

    logic                     f_valid;
    side_t                    f_side;
    logic [NW-1:0]            f_num [2*NUM_AXES];
    logic [DIR_W-1:0]         f_den [2*NUM_AXES];
    logic                     f_neg [2*NUM_AXES];
    logic signed [DATA_W-1:0] d_quo [2*NUM_AXES];

    logic                     valid_pipe_reg [DIV_LAT];
    side_t                    side_pipe_reg  [DIV_LAT];

    // Write configuration registers; ignore unknown indexes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < NUM_AXES; a++)
            begin
                box_min_reg[a] <= '0;
                box_max_reg[a] <= '0;
            end
            range_min_reg <= '0;
            range_max_reg <= Q_MAX;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_BOX_MIN_X: box_min_reg[0] <= cfg_data;
                REG_BOX_MIN_Y: box_min_reg[1] <= cfg_data;
                REG_BOX_MIN_Z: box_min_reg[2] <= cfg_data;
                REG_BOX_MAX_X: box_max_reg[0] <= cfg_data;
                REG_BOX_MAX_Y: box_max_reg[1] <= cfg_data;
                REG_BOX_MAX_Z: box_max_reg[2] <= cfg_data;
                REG_RANGE_MIN: range_min_reg  <= cfg_data;
                REG_RANGE_MAX: range_max_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    assign org = '{ray_org_x, ray_org_y, ray_org_z};
    assign dir = '{direction_x, direction_y, direction_z};
    assign busy = 1'b0;

    rbs_front #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .org       (org),
        .dir       (dir),
        .lo        (box_min_reg),
        .hi        (box_max_reg),
        .out_valid (f_valid),
        .side      (f_side),
        .num       (f_num),
        .den       (f_den),
        .neg       (f_neg)
    );

    for (genvar i = 0; i < 2*NUM_AXES; i++)
    begin : g_div
        rbs_divider #(
            .FRACTION_BITS (FRACTION_BITS)
        ) u_div (
            .clk (clk),
            .num (f_num[i]),
            .den (f_den[i]),
            .neg (f_neg[i]),
            .quo (d_quo[i])
        );
    end

    // Advance valid bits alongside the dividers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < DIV_LAT; s++)
                valid_pipe_reg[s] <= 1'b0;
        end
        else
        begin
            valid_pipe_reg[0] <= f_valid;
            for (int s = 1; s < DIV_LAT; s++)
                valid_pipe_reg[s] <= valid_pipe_reg[s-1];
        end
    end

    // Advance sideband alongside the dividers
    always_ff @(posedge clk)
    begin
        side_pipe_reg[0] <= f_side;
        for (int s = 1; s < DIV_LAT; s++)
            side_pipe_reg[s] <= side_pipe_reg[s-1];
    end

    rbs_back #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (valid_pipe_reg[DIV_LAT-1]),
        .side           (side_pipe_reg[DIV_LAT-1]),
        .quo            (d_quo),
        .range_min      (range_min_reg),
        .range_max      (range_max_reg),
        .out_valid      (done),
        .entry_distance (entry_distance),
        .exit_distance  (exit_distance),
        .hit            (hit)
    );

endmodule
`default_nettype wire

@@ rtl/rbs_front.sv @@
`default_nettype none
module rbs_front #(
    parameter int FRACTION_BITS = rbs_pkg::FRACTION_BITS_DEFAULT
) (
    input  wire logic                                     clk,
    input  wire logic                                     rst_n,
    input  wire logic                                     in_valid,
    input  wire logic signed [rbs_pkg::DATA_W-1:0]        org [rbs_pkg::NUM_AXES],
    input  wire logic signed [rbs_pkg::DIR_W-1:0]         dir [rbs_pkg::NUM_AXES],
    input  wire logic signed [rbs_pkg::DATA_W-1:0]        lo  [rbs_pkg::NUM_AXES],
    input  wire logic signed [rbs_pkg::DATA_W-1:0]        hi  [rbs_pkg::NUM_AXES],
    output logic                                          out_valid,
    output rbs_pkg::side_t                                side,
    output logic [rbs_pkg::DATA_W+FRACTION_BITS:0]        num [2*rbs_pkg::NUM_AXES],
    output logic [rbs_pkg::DIR_W-1:0]                     den [2*rbs_pkg::NUM_AXES],
    output logic                                          neg [2*rbs_pkg::NUM_AXES]
);
    import rbs_pkg::*;

    localparam int NW = DATA_W + 1 + FRACTION_BITS;

    logic                     valid_reg;
    side_t                    side_reg, side_next;
    logic [NW-1:0]            num_reg [2*NUM_AXES];
    logic [NW-1:0]            num_next [2*NUM_AXES];
    logic [DIR_W-1:0]         den_reg [2*NUM_AXES];
    logic [DIR_W-1:0]         den_next [2*NUM_AXES];
    logic                     neg_reg [2*NUM_AXES];
    logic                     neg_next [2*NUM_AXES];

    // Form plane differences, magnitudes, signs and the parallel test
    always_comb
    begin
        logic signed [DATA_W:0] diff;
        logic [DATA_W:0]        mag;
        logic signed [DATA_W:0] bnd;
        logic [DIR_W-1:0]       dmag;
        side_next.miss = 1'b0;
        for (int a = 0; a < NUM_AXES; a++)
        begin
            side_next.zero[a] = (dir[a] == '0);
            if ((dir[a] == '0) && ((org[a] < lo[a]) || (org[a] > hi[a])))
                side_next.miss = 1'b1;
            dmag = dir[a][DIR_W-1] ? DIR_W'(-dir[a]) : DIR_W'(dir[a]);
            for (int s = 0; s < 2; s++)
            begin
                bnd  = (s == 0) ? {lo[a][DATA_W-1], lo[a]} : {hi[a][DATA_W-1], hi[a]};
                diff = bnd - {org[a][DATA_W-1], org[a]};
                mag  = diff[DATA_W] ? (DATA_W+1)'(-diff) : (DATA_W+1)'(diff);
                num_next[2*a+s] = NW'(mag) << FRACTION_BITS;
                den_next[2*a+s] = dmag;
                neg_next[2*a+s] = diff[DATA_W] ^ dir[a][DIR_W-1];
            end
        end
    end

    // Advance the valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    // Hold payload for the dividers
    always_ff @(posedge clk)
    begin
        side_reg <= side_next;
        num_reg  <= num_next;
        den_reg  <= den_next;
        neg_reg  <= neg_next;
    end

    assign out_valid = valid_reg;
    assign side      = side_reg;
    assign num       = num_reg;
    assign den       = den_reg;
    assign neg       = neg_reg;

endmodule
`default_nettype wire

@@ rtl/rbs_divider.sv @@
`default_nettype none
module rbs_divider #(
    parameter int FRACTION_BITS = rbs_pkg::FRACTION_BITS_DEFAULT
) (
    input  wire logic                                  clk,
    input  wire logic [rbs_pkg::DATA_W+FRACTION_BITS:0] num,
    input  wire logic [rbs_pkg::DIR_W-1:0]             den,
    input  wire logic                                  neg,
    output logic signed [rbs_pkg::DATA_W-1:0]          quo
);
    import rbs_pkg::*;

    localparam int NW = DATA_W + 1 + FRACTION_BITS;
    localparam int RW = NW + DIR_W;

    logic [RW-1:0]     rem_reg [QUO_W+1];
    logic [DIR_W-1:0]  den_reg [QUO_W+1];
    logic [QUO_W-1:0]  q_reg   [QUO_W+1];
    logic              ovf_reg [QUO_W+1];
    logic              neg_reg [QUO_W+1];
    logic signed [DATA_W-1:0] quo_reg;

    // Load the first stage and flag quotients that cannot fit the quotient width
    always_ff @(posedge clk)
    begin
        rem_reg[0] <= RW'(num);
        den_reg[0] <= den;
        q_reg[0]   <= '0;
        ovf_reg[0] <= (RW'(num) >= (RW'(den) << QUO_W));
        neg_reg[0] <= neg;
    end

    // One restoring step per stage, most significant quotient bit first
    for (genvar j = 0; j < QUO_W; j++)
    begin : g_step
        localparam int K = QUO_W - 1 - j;
        logic [RW-1:0] sub;
        assign sub = RW'(den_reg[j]) << K;
        always_ff @(posedge clk)
        begin
            den_reg[j+1] <= den_reg[j];
            ovf_reg[j+1] <= ovf_reg[j];
            neg_reg[j+1] <= neg_reg[j];
            if (rem_reg[j] >= sub)
            begin
                rem_reg[j+1] <= rem_reg[j] - sub;
                q_reg[j+1]   <= q_reg[j] | (QUO_W'(1) << K);
            end
            else
            begin
                rem_reg[j+1] <= rem_reg[j];
                q_reg[j+1]   <= q_reg[j];
            end
        end
    end

    // Apply sign and saturate to the signed range
    always_ff @(posedge clk)
    begin
        if (neg_reg[QUO_W])
        begin
            if (ovf_reg[QUO_W] || (q_reg[QUO_W] > QUO_W'(33'h8000_0000)))
                quo_reg <= Q_MIN;
            else
                quo_reg <= DATA_W'(-q_reg[QUO_W]);
        end
        else
        begin
            if (ovf_reg[QUO_W] || q_reg[QUO_W][QUO_W-1])
                quo_reg <= Q_MAX;
            else
                quo_reg <= DATA_W'(q_reg[QUO_W]);
        end
    end

    assign quo = quo_reg;

endmodule
`default_nettype wire

@@ rtl/rbs_back.sv @@
`default_nettype none
module rbs_back #(
    parameter int FRACTION_BITS = rbs_pkg::FRACTION_BITS_DEFAULT
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    input  wire rbs_pkg::side_t                      side,
    input  wire logic signed [rbs_pkg::DATA_W-1:0]   quo [2*rbs_pkg::NUM_AXES],
    input  wire logic signed [rbs_pkg::DATA_W-1:0]   range_min,
    input  wire logic signed [rbs_pkg::DATA_W-1:0]   range_max,
    output logic                                     out_valid,
    output logic signed [rbs_pkg::DATA_W-1:0]        entry_distance,
    output logic signed [rbs_pkg::DATA_W-1:0]        exit_distance,
    output logic                                     hit
);
    import rbs_pkg::*;

    localparam logic signed [DATA_W-1:0] ONE = DATA_W'(1) << FRACTION_BITS;

    logic                     v1_reg, v2_reg;
    logic                     miss1_reg;
    logic signed [DATA_W-1:0] near_reg, near_next, far_reg, far_next;
    logic signed [DATA_W-1:0] entry_reg, entry_next, exit_reg, exit_next;
    logic                     hit_reg, hit_next;

    // Order each plane pair and keep the largest entry and smallest exit over non-parallel axes
    always_comb
    begin
        logic signed [DATA_W-1:0] a;
        logic signed [DATA_W-1:0] b;
        near_next = Q_MIN;
        far_next  = Q_MAX;
        for (int x = 0; x < NUM_AXES; x++)
        begin
            a = (quo[2*x] > quo[2*x+1]) ? quo[2*x+1] : quo[2*x];
            b = (quo[2*x] > quo[2*x+1]) ? quo[2*x] : quo[2*x+1];
            if (!side.zero[x])
            begin
                if (a > near_next)
                    near_next = a;
                if (b < far_next)
                    far_next = b;
            end
        end
    end

    // Clamp to the range and form the hit flag; a parallel miss gives entry one, exit zero, no hit
    always_comb
    begin
        if (miss1_reg)
        begin
            entry_next = ONE;
            exit_next  = '0;
            hit_next   = 1'b0;
        end
        else
        begin
            entry_next = (near_reg > range_min) ? near_reg : range_min;
            exit_next  = (far_reg < range_max) ? far_reg : range_max;
            hit_next   = (exit_next >= entry_next);
        end
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    // Hold payload
    always_ff @(posedge clk)
    begin
        miss1_reg <= side.miss;
        near_reg  <= near_next;
        far_reg   <= far_next;
        entry_reg <= entry_next;
        exit_reg  <= exit_next;
        hit_reg   <= hit_next;
    end

    assign out_valid      = v2_reg;
    assign entry_distance = entry_reg;
    assign exit_distance  = exit_reg;
    assign hit            = hit_reg;

endmodule
`default_nettype wire

@@ rtl/rbs_checker.sv @@
`default_nettype none
`include "ray_box_slab_intersect_top_macros.svh"
module rbs_checker (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 start,
    input  wire logic                                 busy,
    input  wire logic                                 done,
    input  wire logic signed [rbs_pkg::DATA_W-1:0]    entry_distance,
    input  wire logic signed [rbs_pkg::DATA_W-1:0]    exit_distance,
    input  wire logic                                 hit
);
    import rbs_pkg::*;

    // Every accepted transaction yields a result at the end of the pipeline
    `RBS_ASSERT_IMP(a_start_done, clk, rst_n, start && !busy, ##PIPE_LAT done, "result missing")
    // Every result comes from an earlier accepted transaction
    `RBS_ASSERT_IMP(a_done_start, clk, rst_n, done, $past(start && !busy, PIPE_LAT), "spurious result")
    // Hit flag agrees with the reported distances
    `RBS_ASSERT_IMP(a_hit, clk, rst_n, done, hit == (exit_distance >= entry_distance), "bad hit flag")
    // Input side never stalls
    `RBS_ASSERT(a_no_busy, clk, rst_n, !busy, "busy raised")

endmodule

bind ray_box_slab_intersect_top rbs_checker u_rbs_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .done           (done),
    .entry_distance (entry_distance),
    .exit_distance  (exit_distance),
    .hit            (hit)
);
`default_nettype wire

@@ tb/ray_box_slab_intersect_top_tb.sv @@
`default_nettype none
module ray_box_slab_intersect_top_tb;
    import rbs_pkg::*;

    localparam int FRAC = FRACTION_BITS_DEFAULT;
    localparam int DRAIN_CYCLES = PIPE_LAT + 10;

    typedef struct packed {
        logic signed [DATA_W-1:0] entry_d;
        logic signed [DATA_W-1:0] exit_d;
        logic                     hit;
    } slab_result_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic signed [DATA_W-1:0] ray_org_x, ray_org_y, ray_org_z;
    logic signed [DIR_W-1:0]  direction_x, direction_y, direction_z;
    logic                     cfg_we;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [DATA_W-1:0]        cfg_data;
    logic                     done;
    logic signed [DATA_W-1:0] entry_distance, exit_distance;
    logic                     hit;

    // Shadow copy of the box and range registers
    logic signed [DATA_W-1:0] box_regs [0:7];
    slab_result_t expected_hits [$];
    int error_count;
    int burst_left;

    ray_box_slab_intersect_top u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .ray_org_x(ray_org_x), .ray_org_y(ray_org_y), .ray_org_z(ray_org_z),
        .direction_x(direction_x), .direction_y(direction_y),
        .direction_z(direction_z),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .done(done), .entry_distance(entry_distance),
        .exit_distance(exit_distance), .hit(hit)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50000000;
        $display("status: fail");
        $finish;
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        error_count++;
    endtask

    // Saturating fixed point divide, truncated toward zero
    function automatic logic signed [63:0] plane_distance(input logic signed [63:0] num,
                                                          input logic signed [63:0] den);
        logic [63:0] n;
        logic [63:0] d;
        logic [63:0] q;
        logic        neg;
        neg = (num < 0) != (den < 0);
        n = num < 0 ? -num : num;
        d = den < 0 ? -den : den;
        q = (n << FRAC) / d;
        if (neg)
        begin
            if (q > 64'd2147483648) return -64'sd2147483648;
            return -$signed(q);
        end
        if (q > 64'd2147483647) return 64'sd2147483647;
        return $signed(q);
    endfunction

    function automatic slab_result_t slab_predict(input logic signed [DATA_W-1:0] org [3],
                                                  input logic signed [DIR_W-1:0] dir [3]);
        logic signed [63:0] near_t;
        logic signed [63:0] far_t;
        logic signed [63:0] a;
        logic signed [63:0] b;
        logic signed [63:0] t;
        logic signed [63:0] lo;
        logic signed [63:0] hi;
        logic signed [63:0] o;
        slab_result_t r;
        near_t = -64'sd2147483648;
        far_t = 64'sd2147483647;
        for (int ax = 0; ax < NUM_AXES; ax++)
        begin
            lo = box_regs[ax];
            hi = box_regs[3 + ax];
            o = org[ax];
            if (dir[ax] == 0)
            begin
                if (o < lo || o > hi)
                begin
                    r.entry_d = 32'sd1 <<< FRAC;
                    r.exit_d = '0;
                    r.hit = 1'b0;
                    return r;
                end
                continue;
            end
            a = plane_distance(lo - o, 64'(dir[ax]));
            b = plane_distance(hi - o, 64'(dir[ax]));
            if (a > b)
            begin
                t = a;
                a = b;
                b = t;
            end
            if (a > near_t) near_t = a;
            if (b < far_t) far_t = b;
        end
        if (box_regs[REG_RANGE_MIN] > near_t) near_t = box_regs[REG_RANGE_MIN];
        if (box_regs[REG_RANGE_MAX] < far_t) far_t = box_regs[REG_RANGE_MAX];
        r.entry_d = near_t[31:0];
        r.exit_d = far_t[31:0];
        r.hit = far_t >= near_t;
        return r;
    endfunction

    // Check each result against the oldest prediction
    always @(posedge clk)
    begin
        slab_result_t want;
        if (rst_n && done)
        begin
            if (expected_hits.size() == 0)
                report_mismatch("result with no transaction pending");
            else
            begin
                want = expected_hits.pop_front();
                if (entry_distance !== want.entry_d)
                    report_mismatch($sformatf("entry %h want %h", entry_distance, want.entry_d));
                if (exit_distance !== want.exit_d)
                    report_mismatch($sformatf("exit %h want %h", exit_distance, want.exit_d));
                if (hit !== want.hit)
                    report_mismatch($sformatf("hit %b want %b", hit, want.hit));
            end
        end
    end

    task automatic write_reg(input cfg_reg_t idx, input logic [DATA_W-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        box_regs[idx] = val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic write_box(input logic signed [DATA_W-1:0] vals [8]);
        for (int i = 0; i < 8; i++) write_reg(cfg_reg_t'(i), vals[i]);
    endtask

    // Drop start, then wait out the pipeline before touching registers
    task automatic drain_pipe();
        int guard;
        guard = 0;
        start <= 1'b0;
        while (expected_hits.size() != 0 && guard < 100000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    // Send one ray; with gaps set, random gaps between bursts, start held high inside a burst
    task automatic send_ray(input logic signed [DATA_W-1:0] ox, oy, oz,
                            input logic signed [DIR_W-1:0] dx, dy, dz,
                            input bit gaps);
        logic signed [DATA_W-1:0] org [3];
        logic signed [DIR_W-1:0]  dir [3];
        slab_result_t             pred;
        if (gaps && burst_left == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 8);
        end
        if (burst_left > 0) burst_left--;
        start <= 1'b1;
        ray_org_x <= ox; ray_org_y <= oy; ray_org_z <= oz;
        direction_x <= dx; direction_y <= dy; direction_z <= dz;
        org = '{ox, oy, oz};
        dir = '{dx, dy, dz};
        @(posedge clk);
        while (busy) @(posedge clk);
        pred = slab_predict(org, dir);
        expected_hits = {expected_hits, pred};
        @(negedge clk);
    endtask

    function automatic logic signed [DIR_W-1:0] rand_dir();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return 18'sh1FFFF;
            2: return 18'sh20000;
            3: return DIR_W'($signed($urandom_range(0, 8)) - 4);
            default: return DIR_W'($urandom);
        endcase
    endfunction

    function automatic logic signed [DATA_W-1:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return Q_MAX;
            1: return Q_MIN;
            2: return $signed($urandom_range(0, 32'h000A_0000)) - 32'sh0005_0000;
            3: return $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_directed();
        logic signed [DATA_W-1:0] cfg_vals [8];
        cfg_vals = '{-32'sh0001_0000, -32'sh0001_0000, -32'sh0001_0000,
                     32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000,
                     Q_MIN, Q_MAX};
        write_box(cfg_vals);
        // straight hit down the x axis
        send_ray(-32'sh0005_0000, 0, 0, 18'sh10000, 0, 0, 1'b0);
        // parallel miss below and above, origin on faces
        send_ray(0, -32'sh0002_0000, 0, 18'sh10000, 0, 0, 1'b0);
        send_ray(0, 0, 32'sh0002_0000, 18'sh10000, 0, 0, 1'b0);
        send_ray(0, -32'sh0001_0000, 32'sh0001_0000, 18'sh10000, 0, 0, 1'b0);
        // unbounded ray: all directions zero inside the box
        send_ray(0, 0, 0, 0, 0, 0, 1'b0);
        // extremes of origins and directions, saturating quotients
        send_ray(Q_MAX, Q_MIN, Q_MAX, 18'sh00001, 18'sh3FFFF, 18'sh1FFFF, 1'b0);
        send_ray(Q_MIN, Q_MAX, Q_MIN, 18'sh20000, 18'sh00001, 18'sh3FFFF, 1'b0);
        send_ray(Q_MIN, Q_MIN, Q_MIN, 18'sh1FFFF, 18'sh1FFFF, 18'sh1FFFF, 1'b0);
        send_ray(Q_MAX, Q_MAX, Q_MAX, 18'sh20000, 18'sh20000, 18'sh20000, 1'b0);
        send_ray(32'sh0000_8000, -32'sh0000_8000, 0, -18'sh08000, 18'sh04000, 18'sh3, 1'b0);
        drain_pipe();
        // inverted box and tight clamp range
        cfg_vals = '{32'sh0001_0000, Q_MAX, Q_MIN, -32'sh0001_0000, Q_MIN, Q_MAX,
                     32'sh0000_4000, 32'sh0000_8000};
        write_box(cfg_vals);
        send_ray(0, 0, 0, 18'sh10000, 18'sh10000, 18'sh10000, 1'b0);
        send_ray(0, 0, 0, 0, 18'sh10000, 18'sh10000, 1'b0);
        send_ray(0, 0, 0, 18'sh10000, 18'sh10000, 0, 1'b0);
        send_ray(-32'sh0003_0000, 32'sh0003_0000, 0, 18'sh3, -18'sh5, 18'sh7, 1'b0);
        drain_pipe();
        // unknown register index is dropped by the block
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= 4'd15;
        cfg_data <= 32'hDEAD_BEEF;
        @(negedge clk);
        cfg_we <= 1'b0;
        send_ray(0, 0, 0, 18'sh10000, 18'sh10000, 18'sh10000, 1'b0);
        drain_pipe();
    endtask

    task automatic test_random(input int phases, input int per_phase);
        logic signed [DATA_W-1:0] cfg_vals [8];
        logic signed [DATA_W-1:0] lo;
        logic signed [DATA_W-1:0] hi;
        for (int p = 0; p < phases; p++)
        begin
            for (int ax = 0; ax < NUM_AXES; ax++)
            begin
                lo = rand_coord();
                hi = rand_coord();
                if ($urandom_range(0, 4) != 0 && lo > hi)
                begin
                    cfg_vals[ax] = hi;
                    cfg_vals[3 + ax] = lo;
                end
                else
                begin
                    cfg_vals[ax] = lo;
                    cfg_vals[3 + ax] = hi;
                end
            end
            case (p % 3)
                0: begin cfg_vals[6] = Q_MIN; cfg_vals[7] = Q_MAX; end
                1: begin cfg_vals[6] = 0; cfg_vals[7] = rand_coord(); end
                default: begin cfg_vals[6] = rand_coord(); cfg_vals[7] = rand_coord(); end
            endcase
            write_box(cfg_vals);
            for (int i = 0; i < per_phase; i++)
                send_ray(rand_coord(), rand_coord(), rand_coord(),
                         rand_dir(), rand_dir(), rand_dir(), 1'b1);
            drain_pipe();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        ray_org_x = '0; ray_org_y = '0; ray_org_z = '0;
        direction_x = '0; direction_y = '0; direction_z = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        error_count = 0;
        burst_left = 0;
        for (int i = 0; i < 8; i++) box_regs[i] = '0;
        box_regs[REG_RANGE_MAX] = Q_MAX;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        // reset defaults: zero-size box at the origin
        send_ray(0, 0, 0, 18'sh10000, 0, 0, 1'b0);
        send_ray(32'sh0001_0000, 0, 0, 0, 18'sh10000, 0, 1'b0);
        drain_pipe();
        test_directed();
        test_random(13, 100);
        drain_pipe();
        if (error_count == 0 && expected_hits.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
`default_nettype wire

@@ sim.f @@
+incdir+rtl
rtl/rbs_pkg.sv
rtl/rbs_front.sv
rtl/rbs_divider.sv
rtl/rbs_back.sv
rtl/ray_box_slab_intersect_top.sv
rtl/rbs_checker.sv
tb/ray_box_slab_intersect_top_tb.sv
